FILE: hw/rtl/tql_pkg.sv
// Shared types and constants of the tabular Q-learning engine.
// No dependencies; compiled first.
package tql_pkg;

  // Table geometry (power-of-two sizes: row and column concatenate into an address)
  localparam int STATES    = 256;
  localparam int ACTIONS   = 16;
  localparam int ST_W      = $clog2(STATES);
  localparam int ACT_W     = $clog2(ACTIONS);
  localparam int ACT_CNT_W = $clog2(ACTIONS + 1);
  localparam int ADDR_W    = ST_W + ACT_W;
  localparam int DEPTH     = STATES * ACTIONS;
  localparam int Q_W       = 32;

  // Field widths
  localparam int RATE_W    = 17;
  localparam int NACT_W    = 5;
  localparam int DRAW_W    = 16;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [RATE_W-1:0] ONE_Q16 = 17'd65536;

  // Opcodes
  localparam logic OP_CHOOSE = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_LEARN_RATE  = 2'd0;
  localparam logic [1:0] REG_DISCOUNT    = 2'd1;
  localparam logic [1:0] REG_NUM_ACTIONS = 2'd2;

  typedef struct packed {
    logic        [RATE_W-1:0] learn_rate;
    logic        [RATE_W-1:0] discount;
    logic        [NACT_W-1:0] num_actions;
  } cfg_t;

  typedef struct packed {
    logic                     opcode;
    logic        [7:0]        cur_state;
    logic        [3:0]        taken_action;
    logic signed [31:0]       reward_value;
    logic        [7:0]        following_state;
    logic        [RATE_W-1:0] explore_threshold;
    logic        [DRAW_W-1:0] random_draw;
    logic        [DRAW_W-1:0] random_action_draw;
  } in_item_t;

  typedef struct packed {
    logic        [3:0]  chosen_action;
    logic               explored;
    logic signed [31:0] written_q;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [Q_W-1:0]    wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

FILE: hw/rtl/tql_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on tql_pkg.
interface tql_in_if;
  logic               valid;
  logic               ready;
  tql_pkg::in_item_t  item;

  modport source  (output valid, output item, input ready);
  modport sink    (input valid, input item, output ready);
  modport monitor (input valid, input item, input ready);
endinterface

interface tql_out_if;
  logic               valid;
  logic               ready;
  tql_pkg::out_item_t item;

  modport source  (output valid, output item, input ready);
  modport sink    (input valid, input item, output ready);
  modport monitor (input valid, input item, input ready);
endinterface

FILE: hw/rtl/tql_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module tql_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/tql_cfg.sv
// APB-style register block: learn_rate, discount, num_actions.
// Depends on tql_pkg.
module tql_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tql_pkg::APB_AW-1:0] paddr,
  input  logic [tql_pkg::APB_DW-1:0] pwdata,
  output logic [tql_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output tql_pkg::cfg_t             cfg
);
  import tql_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learn_rate  <= 17'd8192;
      cfg.discount    <= 17'd58982;
      cfg.num_actions <= 5'd15;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LEARN_RATE:  cfg.learn_rate  <= pwdata[RATE_W-1:0];
        REG_DISCOUNT:    cfg.discount    <= pwdata[RATE_W-1:0];
        REG_NUM_ACTIONS: cfg.num_actions <= pwdata[NACT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_LEARN_RATE:  prdata = APB_DW'(cfg.learn_rate);
      REG_DISCOUNT:    prdata = APB_DW'(cfg.discount);
      REG_NUM_ACTIONS: prdata = APB_DW'(cfg.num_actions);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/tql_mod.sv
// Restoring remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on tql_pkg. Divisor must be 1..ACTIONS.
module tql_mod (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tql_pkg::DRAW_W-1:0]   dividend,
  input  logic [tql_pkg::ACT_CNT_W-1:0] divisor,
  output logic                         done,
  output logic [tql_pkg::ACT_W-1:0]    rem
);
  import tql_pkg::*;

  localparam int CNT_W = $clog2(DRAW_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DRAW_W-1:0]    shreg;
  logic [ACT_CNT_W-1:0] dvs;
  logic [ACT_CNT_W-1:0] part;
  logic [ACT_CNT_W-1:0] trial;

  // shift in next dividend bit; partial remainder stays below divisor
  assign trial = {part[ACT_CNT_W-2:0], shreg[DRAW_W-1]};
  assign rem   = part[ACT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DRAW_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      part  <= '0;
    end else if (busy) begin
      shreg <= {shreg[DRAW_W-2:0], 1'b0};
      part  <= (trial >= dvs) ? trial - dvs : trial;
    end
  end

endmodule

FILE: hw/rtl/tql_core.sv
// Sequencer and datapath: clearing pass, row scan, epsilon-greedy choice,
// Q update arithmetic and result register. Depends on tql_pkg, tql_if, tql_mod.
module tql_core (
  input  logic                  clk,
  input  logic                  rst,
  input  tql_pkg::cfg_t         cfg,
  tql_in_if.sink                in_ch,
  tql_out_if.source             out_ch,
  output tql_pkg::ram_req_t     ram_req,
  input  logic [tql_pkg::Q_W-1:0] ram_rdata
);
  import tql_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MOD    = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_GMUL   = 4'd4;
  localparam logic [3:0] S_TGT    = 4'd5;
  localparam logic [3:0] S_AMUL   = 4'd6;
  localparam logic [3:0] S_SUM    = 4'd7;
  localparam logic [3:0] S_SAT    = 4'd8;
  localparam logic [3:0] S_RESULT = 4'd9;

  localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
  localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

  logic [3:0]           state;
  logic [ADDR_W-1:0]    clr_addr;

  // latched item
  logic                 op;
  logic [ST_W-1:0]      cur_row;
  logic [ACT_W-1:0]     act;
  logic signed [31:0]   reward;
  logic [ST_W-1:0]      scan_row;
  logic [ACT_CNT_W-1:0] n_act;
  logic [RATE_W-1:0]    alpha;
  logic [RATE_W-1:0]    gamma;

  // scan
  logic [ACT_CNT_W-1:0] scan_idx;
  logic                 rd_pend;
  logic [ACT_W-1:0]     rd_tag;
  logic                 issue;
  logic signed [31:0]   best_val;
  logic [ACT_W-1:0]     best_idx;

  // update arithmetic
  logic signed [49:0]   prod_g;
  logic signed [33:0]   target;
  logic signed [49:0]   prod_k;
  logic signed [51:0]   prod_a;
  logic signed [36:0]   sum;
  logic signed [31:0]   new_q;
  logic [RATE_W-1:0]    keep_rate;

  // result
  logic [ACT_W-1:0]     res_action;
  logic                 res_explored;
  logic                 load_out;

  // modulo unit
  logic                 mod_start;
  logic                 mod_done;
  logic [ACT_W-1:0]     mod_rem;
  logic [ACT_CNT_W-1:0] n_now;
  logic [RATE_W-1:0]    alpha_now;
  logic [RATE_W-1:0]    gamma_now;
  logic                 accept;
  logic                 explore_now;

  // clamped configuration
  always_comb begin
    if (cfg.num_actions == '0) begin
      n_now = ACT_CNT_W'(1);
    end else if (cfg.num_actions > NACT_W'(ACTIONS)) begin
      n_now = ACT_CNT_W'(ACTIONS);
    end else begin
      n_now = cfg.num_actions[ACT_CNT_W-1:0];
    end
    alpha_now = (cfg.learn_rate > ONE_Q16) ? ONE_Q16 : cfg.learn_rate;
    gamma_now = (cfg.discount > ONE_Q16) ? ONE_Q16 : cfg.discount;
  end

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign explore_now = {1'b0, in_ch.item.random_draw} < in_ch.item.explore_threshold;
  assign mod_start   = accept && (in_ch.item.opcode == OP_CHOOSE) && explore_now;
  assign issue       = (state == S_SCAN) && (scan_idx < n_act);
  assign load_out    = (state == S_RESULT) && (!out_ch.valid || out_ch.ready);
  assign keep_rate   = ONE_Q16 - alpha;

  tql_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (in_ch.item.random_action_draw),
    .divisor  (n_now),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // memory port selection
  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = {cur_row, act};
    ram_req.wdata = new_q;
    ram_req.raddr = {scan_row, scan_idx[ACT_W-1:0]};
    case (state)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        ram_req.wdata = '0;
      end
      S_GMUL: begin
        ram_req.raddr = {cur_row, act};
      end
      S_RESULT: begin
        ram_req.we = load_out && (op == OP_UPDATE);
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= issue;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (mod_start) begin
              state <= S_MOD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_RESULT;
          end
        end
        S_SCAN: begin
          if (!issue && !rd_pend) begin
            state <= (op == OP_UPDATE) ? S_GMUL : S_RESULT;
          end
        end
        S_GMUL:   state <= S_TGT;
        S_TGT:    state <= S_AMUL;
        S_AMUL:   state <= S_SUM;
        S_SUM:    state <= S_SAT;
        S_SAT:    state <= S_RESULT;
        S_RESULT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  // item capture, scan and arithmetic
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= in_ch.item.opcode;
      cur_row  <= in_ch.item.cur_state[ST_W-1:0];
      act      <= in_ch.item.taken_action[ACT_W-1:0];
      reward   <= in_ch.item.reward_value;
      scan_row <= (in_ch.item.opcode == OP_UPDATE) ?
                  in_ch.item.following_state[ST_W-1:0] : in_ch.item.cur_state[ST_W-1:0];
      n_act    <= n_now;
      alpha    <= alpha_now;
      gamma    <= gamma_now;
      scan_idx <= '0;
      res_action   <= '0;
      res_explored <= mod_start;
      new_q        <= '0;
    end
    if (issue) begin
      scan_idx <= scan_idx + 1'b1;
      rd_tag   <= scan_idx[ACT_W-1:0];
    end
    // running maximum, strict compare keeps the lowest index on ties
    if (rd_pend && ((rd_tag == '0) || ($signed(ram_rdata) > best_val))) begin
      best_val <= $signed(ram_rdata);
      best_idx <= rd_tag;
    end
    case (state)
      S_MOD: begin
        if (mod_done) begin
          res_action <= mod_rem;
        end
      end
      S_SCAN: begin
        if (!issue && !rd_pend && (op == OP_CHOOSE)) begin
          res_action <= best_idx;
        end
      end
      S_GMUL: begin
        prod_g <= $signed({1'b0, gamma}) * best_val;
      end
      S_TGT: begin
        target <= $signed({{2{reward[31]}}, reward}) + $signed(prod_g[49:16]);
        prod_k <= $signed({1'b0, keep_rate}) * $signed(ram_rdata);
      end
      S_AMUL: begin
        prod_a <= $signed({1'b0, alpha}) * target;
      end
      S_SUM: begin
        sum <= $signed({{3{prod_k[49]}}, prod_k[49:16]}) +
               $signed({prod_a[51], prod_a[51:16]});
      end
      S_SAT: begin
        if (sum > SAT_MAX) begin
          new_q <= 32'sh7FFFFFFF;
        end else if (sum < SAT_MIN) begin
          new_q <= 32'sh80000000;
        end else begin
          new_q <= sum[31:0];
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.item.chosen_action <= 4'(res_action);
      out_ch.item.explored      <= res_explored;
      out_ch.item.written_q     <= new_q;
    end
  end

endmodule

FILE: hw/rtl/tabular_q_learning_engine.sv
// Tabular Q-learning engine, epsilon-greedy. One transaction in flight at a time.
// Result paths: choose exploring runs the 16-step remainder unit; choose exploiting
// scans the row, N = active actions, one Q read per cycle; update scans, then multiplies.
// Input ready again the cycle after the result is loaded.
// Reset: synchronous; a clearing pass zeroes the whole Q table, with input
// ready held low meanwhile (register writes are taken throughout).
module tabular_q_learning_engine (
  input  logic                      clk,
  input  logic                      rst,
  tql_in_if.sink                    in_ch,
  tql_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tql_pkg::APB_AW-1:0] paddr,
  input  logic [tql_pkg::APB_DW-1:0] pwdata,
  output logic [tql_pkg::APB_DW-1:0] prdata,
  output logic                      pready
);
  import tql_pkg::*;

  cfg_t            cfg;
  ram_req_t        ram_req;
  logic [Q_W-1:0]  ram_rdata;

  // configuration registers
  tql_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer and datapath
  tql_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // Q table
  tql_ram #(
    .WIDTH (Q_W),
    .DEPTH (DEPTH)
  ) u_qtab (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: hw/rtl/tql_checker.sv
// Port-level checker for the Q-learning engine, bound to the top level.
// Depends on tql_pkg.
module tql_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tql_pkg::out_item_t  out_item
);
  import tql_pkg::*;

  // reset starts the clearing pass: nothing offered or taken right after
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("activity right after reset");

  // one item at a time: no second transaction in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

  // a nonzero written value only comes from an update result
  a_update_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.written_q != 0) |->
      (out_item.chosen_action == 0) && !out_item.explored)
    else $error("update result carries choose fields");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

endmodule

bind tabular_q_learning_engine tql_checker u_tql_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.item)
);
